// ===== hdl/v3alu_pkg.sv =====
// Shared types, constants and saturation helpers for the three-component vector ALU.
// Used by every module under hdl; it depends on nothing else.
package v3alu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int ACC_W     = 66;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int SQ_STEPS  = SQ_W / 2;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int PIPE_REGS = 4 + SQ_STEPS + 1 + NUM_W + 1;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DIV   = 3'd3,
        OP_DOT   = 3'd4,
        OP_CROSS = 3'd5,
        OP_MAG   = 3'd6,
        OP_NORM  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [2:0][WORD_W-1:0] vec_t;
    typedef logic [2:0][NUM_W-1:0] numv_t;

    localparam word_t WORD_MAX = 32'h7FFF_FFFF;
    localparam word_t WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        word_t value;
        logic  sat;
    } sat_t;

    // Payload that travels beside the square root stages.
    typedef struct packed {
        op_t   op;
        vec_t  a;
        word_t s;
        vec_t  r;
        word_t sc;
        logic  sat;
    } front_side_t;

    // Payload that travels beside the divider stages.
    typedef struct packed {
        op_t        op;
        logic [2:0] neg;
        logic       dz;
        vec_t       r;
        word_t      sc;
        logic       sat;
    } div_side_t;

    function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
        sat_t res;
        if (v[ACC_W-1:WORD_W-1] == '0 || v[ACC_W-1:WORD_W-1] == '1) begin
            res.value = v[WORD_W-1:0];
            res.sat   = 1'b0;
        end else if (v[ACC_W-1]) begin
            res.value = WORD_MIN;
            res.sat   = 1'b1;
        end else begin
            res.value = WORD_MAX;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

    function automatic sat_t sat_mag(input logic [NUM_W-1:0] q, input logic neg);
        sat_t  res;
        word_t lo;
        logic  hi;
        lo = q[WORD_W-1:0];
        hi = |q[NUM_W-1:WORD_W];
        if (neg) begin
            if (hi || lo > WORD_MIN) begin
                res.value = WORD_MIN;
                res.sat   = 1'b1;
            end else begin
                res.value = '0 - lo;
                res.sat   = 1'b0;
            end
        end else begin
            if (hi || lo[WORD_W-1]) begin
                res.value = WORD_MAX;
                res.sat   = 1'b1;
            end else begin
                res.value = lo;
                res.sat   = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic word_t abs_word(input word_t v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== hdl/v3alu_front.sv =====
// Front end of the vector ALU: input register, multipliers, sums and the results
// that need no root or quotient. Depends on v3alu_pkg.
module v3alu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  v3alu_pkg::op_t              op,
    input  v3alu_pkg::vec_t             a,
    input  v3alu_pkg::vec_t             b,
    input  v3alu_pkg::word_t            s,
    output logic                        out_valid,
    output logic [v3alu_pkg::SQ_W-1:0]  sq,
    output v3alu_pkg::front_side_t      side
);

    localparam int W  = v3alu_pkg::WORD_W;
    localparam int PW = 2 * v3alu_pkg::WORD_W;
    localparam int AW = v3alu_pkg::ACC_W;

    // Stage 0: request register.
    logic             v0_reg;
    v3alu_pkg::op_t   op0_reg;
    v3alu_pkg::vec_t  a0_reg, b0_reg;
    v3alu_pkg::word_t s0_reg;

    // Stage 1: products and component sums.
    logic                 v1_reg;
    v3alu_pkg::op_t       op1_reg;
    v3alu_pkg::vec_t      a1_reg;
    v3alu_pkg::word_t     s1_reg;
    logic signed [PW-1:0] p0_reg [3];
    logic signed [PW-1:0] p1_reg [3];
    logic signed [W:0]    as1_reg [3];
    logic signed [PW-1:0] p0_next [3];
    logic signed [PW-1:0] p1_next [3];
    logic signed [W:0]    as1_next [3];

    // Stage 2: lane sums and the three-term sum.
    logic                 v2_reg;
    v3alu_pkg::op_t       op2_reg;
    v3alu_pkg::vec_t      a2_reg;
    v3alu_pkg::word_t     s2_reg;
    logic signed [W:0]    as2_reg [3];
    logic signed [AW-1:0] lane_reg [3];
    logic signed [AW-1:0] dot_reg;
    logic signed [AW-1:0] lane_next [3];
    logic signed [AW-1:0] dot_next;

    // Stage 3: saturated early results.
    logic                            v3_reg;
    v3alu_pkg::front_side_t          side_reg, side_next;
    logic [v3alu_pkg::SQ_W-1:0]      sq_reg;

    v3alu_pkg::vec_t ma, mb, mc, md;

    always_comb begin
        int j;
        int k;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            case (op0_reg)
                v3alu_pkg::OP_SCALE: begin
                    ma[i] = a0_reg[i];
                    mb[i] = s0_reg;
                end
                v3alu_pkg::OP_CROSS: begin
                    ma[i] = a0_reg[j];
                    mb[i] = b0_reg[k];
                end
                v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
                    ma[i] = a0_reg[i];
                    mb[i] = a0_reg[i];
                end
                default: begin
                    ma[i] = a0_reg[i];
                    mb[i] = b0_reg[i];
                end
            endcase
            mc[i] = (op0_reg == v3alu_pkg::OP_CROSS) ? a0_reg[k] : '0;
            md[i] = b0_reg[j];
            p0_next[i] = $signed(ma[i]) * $signed(mb[i]);
            p1_next[i] = $signed(mc[i]) * $signed(md[i]);
            if (op0_reg == v3alu_pkg::OP_SUB) begin
                as1_next[i] = $signed({a0_reg[i][W-1], a0_reg[i]})
                            - $signed({b0_reg[i][W-1], b0_reg[i]});
            end else begin
                as1_next[i] = $signed({a0_reg[i][W-1], a0_reg[i]})
                            + $signed({b0_reg[i][W-1], b0_reg[i]});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lane_next[i] = AW'(p0_reg[i]) - AW'(p1_reg[i]);
        end
        dot_next = AW'(p0_reg[0]) + AW'(p0_reg[1]) + AW'(p0_reg[2]);
    end

    always_comb begin
        v3alu_pkg::sat_t t;
        side_next.op  = op2_reg;
        side_next.a   = a2_reg;
        side_next.s   = s2_reg;
        side_next.r   = '0;
        side_next.sc  = '0;
        side_next.sat = 1'b0;
        t = '0;
        case (op2_reg)
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    t = v3alu_pkg::sat_acc(AW'(as2_reg[i]));
                    side_next.r[i] = t.value;
                    side_next.sat  = side_next.sat | t.sat;
                end
            end
            v3alu_pkg::OP_SCALE, v3alu_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    t = v3alu_pkg::sat_acc(lane_reg[i] >>> v3alu_pkg::FRAC_BITS);
                    side_next.r[i] = t.value;
                    side_next.sat  = side_next.sat | t.sat;
                end
            end
            v3alu_pkg::OP_DOT: begin
                t = v3alu_pkg::sat_acc(dot_reg >>> v3alu_pkg::FRAC_BITS);
                side_next.sc  = t.value;
                side_next.sat = t.sat;
            end
            default: begin
                side_next.sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        op0_reg  <= op;
        a0_reg   <= a;
        b0_reg   <= b;
        s0_reg   <= s;
        op1_reg  <= op0_reg;
        a1_reg   <= a0_reg;
        s1_reg   <= s0_reg;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        as1_reg  <= as1_next;
        op2_reg  <= op1_reg;
        a2_reg   <= a1_reg;
        s2_reg   <= s1_reg;
        as2_reg  <= as1_reg;
        lane_reg <= lane_next;
        dot_reg  <= dot_next;
        side_reg <= side_next;
        // For magnitude the sum of squares is nonnegative and below 2^64.
        sq_reg   <= dot_reg[v3alu_pkg::SQ_W-1:0];
    end

    assign out_valid = v3_reg;
    assign sq        = sq_reg;
    assign side      = side_reg;

endmodule

// ===== hdl/v3alu_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, for the vector ALU.
// Depends on v3alu_pkg.
module v3alu_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [v3alu_pkg::SQ_W-1:0]    sq,
    input  v3alu_pkg::front_side_t        side,
    output logic                          out_valid,
    output logic [v3alu_pkg::ROOT_W-1:0]  root,
    output v3alu_pkg::front_side_t        out_side
);

    localparam int N  = v3alu_pkg::SQ_STEPS;
    localparam int SW = v3alu_pkg::SQ_W;

    logic [N-1:0]            v_reg, v_next;
    logic [SW-1:0]           rem_reg [N];
    logic [SW-1:0]           res_reg [N];
    v3alu_pkg::front_side_t  side_reg [N];
    logic [SW-1:0]           rem_next [N];
    logic [SW-1:0]           res_next [N];
    v3alu_pkg::front_side_t  side_next [N];
    logic [SW-1:0]           rem_in [N];
    logic [SW-1:0]           res_in [N];
    logic [SW-1:0]           trial [N];

    // Stage k tries the bit of weight 4^(N-1-k) against the remainder.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                v_next[k]    = in_valid;
                rem_in[k]    = sq;
                res_in[k]    = '0;
                side_next[k] = side;
            end else begin
                v_next[k]    = v_reg[k-1];
                rem_in[k]    = rem_reg[k-1];
                res_in[k]    = res_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            trial[k] = res_in[k] + (SW'(1) << (SW - 2 - 2 * k));
            if (rem_in[k] >= trial[k]) begin
                rem_next[k] = rem_in[k] - trial[k];
                res_next[k] = (res_in[k] >> 1) + (SW'(1) << (SW - 2 - 2 * k));
            end else begin
                rem_next[k] = rem_in[k];
                res_next[k] = res_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        side_reg <= side_next;
    end

    assign out_valid = v_reg[N-1];
    assign root      = res_reg[N-1][v3alu_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hdl/v3alu_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per
// stage. Depends on v3alu_pkg.
module v3alu_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  v3alu_pkg::numv_t        num,
    input  v3alu_pkg::word_t        den,
    input  v3alu_pkg::div_side_t    side,
    output logic                    out_valid,
    output v3alu_pkg::numv_t        quot,
    output v3alu_pkg::div_side_t    out_side
);

    localparam int N = v3alu_pkg::NUM_W;
    localparam int W = v3alu_pkg::WORD_W;

    logic [N-1:0]          v_reg, v_next;
    logic [2:0][W-1:0]     rem_reg [N];
    v3alu_pkg::numv_t      work_reg [N];
    v3alu_pkg::word_t      den_reg [N];
    v3alu_pkg::div_side_t  side_reg [N];
    logic [2:0][W-1:0]     rem_next [N];
    v3alu_pkg::numv_t      work_next [N];
    v3alu_pkg::word_t      den_next [N];
    v3alu_pkg::div_side_t  side_next [N];
    logic [2:0][W-1:0]     rem_in [N];
    v3alu_pkg::numv_t      work_in [N];
    logic [W:0]            shifted [N][3];
    logic [W:0]            diff [N][3];

    // The work word shifts dividend bits out at the top and quotient bits in at the
    // bottom, so after the last stage it holds the quotient.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                v_next[k]    = in_valid;
                rem_in[k]    = '0;
                work_in[k]   = num;
                den_next[k]  = den;
                side_next[k] = side;
            end else begin
                v_next[k]    = v_reg[k-1];
                rem_in[k]    = rem_reg[k-1];
                work_in[k]   = work_reg[k-1];
                den_next[k]  = den_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            for (int l = 0; l < 3; l++) begin
                shifted[k][l] = {rem_in[k][l], work_in[k][l][N-1]};
                diff[k][l]    = shifted[k][l] - {1'b0, den_next[k]};
                if (shifted[k][l] >= {1'b0, den_next[k]}) begin
                    rem_next[k][l]  = diff[k][l][W-1:0];
                    work_next[k][l] = {work_in[k][l][N-2:0], 1'b1};
                end else begin
                    rem_next[k][l]  = shifted[k][l][W-1:0];
                    work_next[k][l] = {work_in[k][l][N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        den_reg  <= den_next;
        side_reg <= side_next;
    end

    assign out_valid = v_reg[N-1];
    assign quot      = work_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hdl/vector3_alu.sv =====
// Three-component vector ALU, fully pipelined: one request per clock, busy stays low.
// The request passes 4 front stages, 32 root stages, 1 setup register, 48 divider
// stages and 1 output register before done goes high.
// Every opcode takes the same path, so results leave in request order.
// Reset clears the valid bits only; the receiver cannot stall, so nothing ever waits.
module vector3_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar_in,
    output logic               done,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] scalar_out,
    output logic [1:0]         status
);

    localparam int W = v3alu_pkg::WORD_W;

    v3alu_pkg::vec_t  a_vec, b_vec;

    logic                            fe_valid;
    logic [v3alu_pkg::SQ_W-1:0]      fe_sq;
    v3alu_pkg::front_side_t          fe_side;

    logic                            sq_valid;
    logic [v3alu_pkg::ROOT_W-1:0]    sq_root;
    v3alu_pkg::front_side_t          sq_side;

    logic                            d_valid_reg;
    v3alu_pkg::numv_t                d_num_reg, d_num_next;
    v3alu_pkg::word_t                d_den_reg, d_den_next;
    v3alu_pkg::div_side_t            d_side_reg, d_side_next;

    logic                            dv_valid;
    v3alu_pkg::numv_t                dv_quot;
    v3alu_pkg::div_side_t            dv_side;

    logic                            done_reg;
    v3alu_pkg::vec_t                 r_reg, r_next;
    v3alu_pkg::word_t                sc_reg, sc_next;
    v3alu_pkg::status_t              status_reg, status_next;

    assign a_vec = {a_z, a_y, a_x};
    assign b_vec = {b_z, b_y, b_x};
    assign busy  = 1'b0;

    v3alu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .op        (v3alu_pkg::op_t'(opcode)),
        .a         (a_vec),
        .b         (b_vec),
        .s         (scalar_in),
        .out_valid (fe_valid),
        .sq        (fe_sq),
        .side      (fe_side)
    );

    v3alu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .sq        (fe_sq),
        .side      (fe_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Divider setup: divide uses |scalar|, normalize uses the unsaturated magnitude.
    always_comb begin
        logic is_div;
        logic is_norm;
        is_div  = (sq_side.op == v3alu_pkg::OP_DIV);
        is_norm = (sq_side.op == v3alu_pkg::OP_NORM);
        for (int i = 0; i < 3; i++) begin
            d_num_next[i] = {v3alu_pkg::abs_word(sq_side.a[i]),
                             {v3alu_pkg::FRAC_BITS{1'b0}}};
            d_side_next.neg[i] = sq_side.a[i][W-1] ^ (is_div & sq_side.s[W-1]);
        end
        d_den_next = is_div ? v3alu_pkg::abs_word(sq_side.s) : sq_root;
        d_side_next.op  = sq_side.op;
        d_side_next.dz  = (is_div | is_norm) & (d_den_next == '0);
        d_side_next.r   = sq_side.r;
        d_side_next.sc  = sq_side.sc;
        d_side_next.sat = sq_side.sat;
        if (sq_side.op == v3alu_pkg::OP_MAG) begin
            d_side_next.sc  = sq_root[W-1] ? v3alu_pkg::WORD_MAX : sq_root;
            d_side_next.sat = sq_root[W-1];
        end
    end

    v3alu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .num       (d_num_reg),
        .den       (d_den_reg),
        .side      (d_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    always_comb begin
        v3alu_pkg::sat_t t;
        logic            sat;
        t       = '0;
        r_next  = dv_side.r;
        sc_next = dv_side.sc;
        sat     = dv_side.sat;
        if (dv_side.op == v3alu_pkg::OP_DIV || dv_side.op == v3alu_pkg::OP_NORM) begin
            r_next  = '0;
            sc_next = '0;
            sat     = 1'b0;
            if (!dv_side.dz) begin
                for (int i = 0; i < 3; i++) begin
                    t         = v3alu_pkg::sat_mag(dv_quot[i], dv_side.neg[i]);
                    r_next[i] = t.value;
                    sat       = sat | t.sat;
                end
            end
        end
        if (dv_side.dz) begin
            status_next = v3alu_pkg::ST_DZ;
        end else if (sat) begin
            status_next = v3alu_pkg::ST_SAT;
        end else begin
            status_next = v3alu_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            d_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            d_valid_reg <= sq_valid;
            done_reg    <= dv_valid;
        end
    end

    always_ff @(posedge clk) begin
        d_num_reg  <= d_num_next;
        d_den_reg  <= d_den_next;
        d_side_reg <= d_side_next;
        r_reg      <= r_next;
        sc_reg     <= sc_next;
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign r_x        = r_reg[0];
    assign r_y        = r_reg[1];
    assign r_z        = r_reg[2];
    assign scalar_out = sc_reg;
    assign status     = status_reg;

`ifndef ASSERT_OFF
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(v3alu_pkg::PIPE_REGS) done)
        else $error("request did not complete after the pipeline latency");

    a_dz_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == v3alu_pkg::ST_DZ |->
            r_x == 0 && r_y == 0 && r_z == 0 && scalar_out == 0)
        else $error("divide by zero result carries nonzero values");

    a_vector_or_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> scalar_out == 0 || (r_x == 0 && r_y == 0 && r_z == 0))
        else $error("result carries both a vector and a scalar");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == v3alu_pkg::ST_OK || status == v3alu_pkg::ST_DZ
              || status == v3alu_pkg::ST_SAT)
        else $error("unknown status code on a result");
`endif

endmodule
